>>> src/sltf_pkg.sv
package sltf_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 24;

    localparam int GAIN_FRAC = 24;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int WARM_W    = 16;
    localparam int EVT_W     = 24;

    localparam int RATIO_W    = 24;
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_SH   = RATIO_W - RATIO_FRAC;
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [CFG_IDX_W-1:0] CFG_STA_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LTA_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ON   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_OFF  = 3'd4;

    localparam logic [GAIN_W-1:0] STA_GAIN_RST  = 25'd167772;
    localparam logic [GAIN_W-1:0] LTA_GAIN_RST  = 25'd16777;
    localparam logic [WARM_W-1:0] INIT_LEN_RST  = 16'd500;
    localparam logic [EVT_W-1:0]  EVENT_ON_RST  = 24'd196608;
    localparam logic [EVT_W-1:0]  EVENT_OFF_RST = 24'd98304;

    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_LOAD,
        ALU_ADD,
        ALU_SUB,
        ALU_CHK,
        ALU_MSTEP,
        ALU_DSTEP
    } t_alu_op;

endpackage

>>> src/sta_lta_trigger_freeze.sv
// Warm-up: a divide pass sets both averages, ratio unity. Else: gain passes on the
// long-term average (not while frozen) and the short-term one, then the ratio division,
// whose quotient steps a saturated ratio skips. An earlier result still waiting
// downstream holds the final step. One bit-serial add/subtract unit does one gain bit or
// one quotient bit per cycle. One request at a time; the next is taken the cycle after
// the result is registered, also while that result still waits downstream. Synchronous
// active-low reset: registers to defaults, averages, count and freeze state to zero.
module sta_lta_trigger_freeze #(
    parameter int SAMPLE_BITS = sltf_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = sltf_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sltf_pkg::RATIO_W-1:0]     o_ratio,
    output logic                             o_triggered,
    output logic                             o_warming_up,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sltf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sltf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AVG_W  = SAMPLE_BITS - 1 + FRAC_BITS;
    localparam int LO_W   = (AVG_W > sltf_pkg::GAIN_W) ? AVG_W : sltf_pkg::GAIN_W;
    localparam int CNT_W  = $clog2(LO_W);
    localparam int GW     = sltf_pkg::GAIN_W;
    localparam int RW     = sltf_pkg::RATIO_W;
    localparam int RSH    = sltf_pkg::RATIO_SH;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_DIFF2,
        S_LOAD,
        S_STEP,
        S_APPLY,
        S_RLOAD,
        S_RCHK,
        S_RSTEP,
        S_TRIG,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        P_WARM,
        P_LTA,
        P_STA
    } t_phase;

    t_state r_state;
    t_phase r_phase;

    logic [GW-1:0]                    r_sta_gain;
    logic [GW-1:0]                    r_lta_gain;
    logic [sltf_pkg::WARM_W-1:0]      r_init_len;
    logic [sltf_pkg::EVT_W-1:0]       r_event_on;
    logic [sltf_pkg::EVT_W-1:0]       r_event_off;

    logic [AVG_W-1:0]                 r_short;
    logic [AVG_W-1:0]                 r_long;
    logic [sltf_pkg::WARM_W-1:0]      r_warm;
    logic                             r_frozen;

    logic [AVG_W-1:0]                 r_abs;
    logic [AVG_W-1:0]                 r_d;
    logic                             r_neg;
    logic                             r_sat;
    logic [CNT_W-1:0]                 r_cnt;
    logic [RW-1:0]                    r_rres;
    logic                             r_wflag;

    logic                             r_ovalid;
    logic [RW-1:0]                    r_ratio;
    logic                             r_trig;
    logic                             r_wout;

    sltf_pkg::t_alu_op                alu_op;
    logic [AVG_W-1:0]                 alu_a;
    logic [AVG_W-1:0]                 alu_b;
    logic [LO_W-1:0]                  alu_lo_in;
    logic [AVG_W-1:0]                 alu_sum;
    logic                             alu_borrow;
    logic [AVG_W-1:0]                 alu_mres;
    logic [LO_W-1:0]                  alu_lo;

    logic [SAMPLE_BITS-1:0]           mag;
    logic [SAMPLE_BITS-2:0]           abs_val;
    logic [AVG_W-1:0]                 abs_fix;
    logic [AVG_W-1:0]                 avg_sel;
    logic [AVG_W-1:0]                 tgt_sel;
    logic [GW-1:0]                    gain_raw;
    logic [GW-1:0]                    gain_c;
    logic [AVG_W-1:0]                 warm_div;
    logic [RW-1:0]                    ratio_val;
    logic                             warm_ph;
    logic                             in_acc;

    always_comb begin
        mag      = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        abs_val  = mag[SAMPLE_BITS-1] ? '1 : mag[SAMPLE_BITS-2:0];
        abs_fix  = AVG_W'(abs_val) << FRAC_BITS;
        warm_ph  = (r_phase == P_WARM);
        avg_sel  = (r_phase == P_STA) ? r_short : r_long;
        tgt_sel  = (r_phase == P_LTA) ? r_short : r_abs;
        gain_raw = (r_phase == P_LTA) ? r_lta_gain : r_sta_gain;
        gain_c   = gain_raw[GW-1] ? {1'b1, {(GW-1){1'b0}}} : gain_raw;
        warm_div = AVG_W'({1'b0, r_warm} + 17'd1);
        ratio_val = r_sat ? sltf_pkg::RATIO_MAX : alu_lo[RW-1:0];
        in_acc   = i_in_valid && (r_state == S_IDLE);
    end

    always_comb begin
        alu_op    = sltf_pkg::ALU_HOLD;
        alu_a     = '0;
        alu_b     = '0;
        alu_lo_in = '0;
        unique case (r_state)
            S_DIFF: begin
                alu_op = sltf_pkg::ALU_SUB;
                alu_a  = tgt_sel;
                alu_b  = avg_sel;
            end
            S_DIFF2: begin
                alu_op = sltf_pkg::ALU_SUB;
                alu_a  = avg_sel;
                alu_b  = tgt_sel;
            end
            S_LOAD: begin
                alu_op    = sltf_pkg::ALU_LOAD;
                alu_lo_in = warm_ph ? (LO_W'(r_d) << (LO_W - AVG_W)) : LO_W'(gain_c);
            end
            S_STEP: begin
                alu_op = warm_ph ? sltf_pkg::ALU_DSTEP : sltf_pkg::ALU_MSTEP;
                alu_b  = warm_ph ? warm_div : r_d;
            end
            S_APPLY: begin
                alu_op = r_neg ? sltf_pkg::ALU_SUB : sltf_pkg::ALU_ADD;
                alu_a  = avg_sel;
                alu_b  = warm_ph ? alu_lo[AVG_W-1:0] : alu_mres;
            end
            S_RLOAD: begin
                alu_op    = sltf_pkg::ALU_LOAD;
                alu_a     = r_short >> RSH;
                alu_lo_in = LO_W'(r_short[RSH-1:0]) << (LO_W - RSH);
            end
            S_RCHK: begin
                alu_op = sltf_pkg::ALU_CHK;
                alu_b  = r_long;
            end
            S_RSTEP: begin
                alu_op = sltf_pkg::ALU_DSTEP;
                alu_b  = r_long;
            end
            default: begin
                alu_op = sltf_pkg::ALU_HOLD;
            end
        endcase
    end

    sltf_alu #(
        .AVG_W (AVG_W),
        .LO_W  (LO_W)
    ) u_alu (
        .i_clk    (i_clk),
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_lo     (alu_lo_in),
        .o_sum    (alu_sum),
        .o_borrow (alu_borrow),
        .o_mres   (alu_mres),
        .o_lo     (alu_lo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= P_WARM;
            r_ovalid    <= 1'b0;
            r_sta_gain  <= sltf_pkg::STA_GAIN_RST;
            r_lta_gain  <= sltf_pkg::LTA_GAIN_RST;
            r_init_len  <= sltf_pkg::INIT_LEN_RST;
            r_event_on  <= sltf_pkg::EVENT_ON_RST;
            r_event_off <= sltf_pkg::EVENT_OFF_RST;
            r_short     <= '0;
            r_long      <= '0;
            r_warm      <= '0;
            r_frozen    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sltf_pkg::CFG_STA_GAIN:  r_sta_gain  <= i_cfg_data[GW-1:0];
                    sltf_pkg::CFG_LTA_GAIN:  r_lta_gain  <= i_cfg_data[GW-1:0];
                    sltf_pkg::CFG_INIT_LEN:  r_init_len  <= i_cfg_data[sltf_pkg::WARM_W-1:0];
                    sltf_pkg::CFG_EVENT_ON:  r_event_on  <= i_cfg_data[sltf_pkg::EVT_W-1:0];
                    sltf_pkg::CFG_EVENT_OFF: r_event_off <= i_cfg_data[sltf_pkg::EVT_W-1:0];
                    default: begin
                        r_event_off <= r_event_off;
                    end
                endcase
            end

            if (r_ovalid && !i_out_stall && (r_state != S_FINISH)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_abs <= abs_fix;
                        if (r_warm < r_init_len) begin
                            r_phase <= P_WARM;
                        end else if (!r_frozen) begin
                            r_phase <= P_LTA;
                        end else begin
                            r_phase <= P_STA;
                        end
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg <= alu_borrow;
                    r_d   <= alu_sum;
                    r_state <= alu_borrow ? S_DIFF2 : S_LOAD;
                end
                S_DIFF2: begin
                    r_d     <= alu_sum;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= warm_ph ? CNT_W'(AVG_W - 1) : CNT_W'(GW - 1);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_APPLY: begin
                    unique case (r_phase)
                        P_WARM: begin
                            r_long  <= alu_sum;
                            r_short <= alu_sum;
                            r_warm  <= r_warm + 1'b1;
                            r_rres  <= sltf_pkg::RATIO_ONE;
                            r_wflag <= 1'b1;
                            r_state <= S_FINISH;
                        end
                        P_LTA: begin
                            r_long  <= alu_sum;
                            r_phase <= P_STA;
                            r_state <= S_DIFF;
                        end
                        default: begin
                            r_short <= alu_sum;
                            r_wflag <= 1'b0;
                            r_state <= S_RLOAD;
                        end
                    endcase
                end
                S_RLOAD: begin
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    r_sat <= !alu_borrow;
                    r_cnt <= CNT_W'(RW - 1);
                    r_state <= alu_borrow ? S_RSTEP : S_TRIG;
                end
                S_RSTEP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_TRIG;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_TRIG: begin
                    r_rres <= ratio_val;
                    if (!r_frozen && (ratio_val > r_event_on)) begin
                        r_frozen <= 1'b1;
                    end else if (r_frozen && (ratio_val < r_event_off)) begin
                        r_frozen <= 1'b0;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ratio  <= r_rres;
                        r_trig   <= r_frozen;
                        r_wout   <= r_wflag;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_ovalid;
    assign o_ratio      = r_ratio;
    assign o_triggered  = r_trig;
    assign o_warming_up = r_wout;

    a_warm_ratio_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_warming_up) |-> (o_ratio == sltf_pkg::RATIO_ONE))
        else $error("warm-up result without unity ratio");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted without going busy");

    a_freeze_only_on_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_frozen)) |-> ($past(r_state) == S_TRIG))
        else $error("trigger state changed outside the decision step");

endmodule

>>> src/sltf_alu.sv
module sltf_alu #(
    parameter int AVG_W = sltf_pkg::SAMPLE_BITS_DEF - 1 + sltf_pkg::FRAC_BITS_DEF,
    parameter int LO_W  = (AVG_W > sltf_pkg::GAIN_W) ? AVG_W : sltf_pkg::GAIN_W
) (
    input  logic              i_clk,
    input  sltf_pkg::t_alu_op i_op,
    input  logic [AVG_W-1:0]  i_a,
    input  logic [AVG_W-1:0]  i_b,
    input  logic [LO_W-1:0]   i_lo,
    output logic [AVG_W-1:0]  o_sum,
    output logic              o_borrow,
    output logic [AVG_W-1:0]  o_mres,
    output logic [LO_W-1:0]   o_lo
);

    logic [AVG_W:0]   r_hi;
    logic [LO_W-1:0]  r_lo;
    logic [AVG_W:0]   x;
    logic [AVG_W:0]   y;
    logic             sub;
    logic [AVG_W+1:0] s;
    logic             borrow;

    always_comb begin
        x   = r_hi;
        y   = '0;
        sub = 1'b0;
        unique case (i_op)
            sltf_pkg::ALU_ADD: begin
                x = {1'b0, i_a};
                y = {1'b0, i_b};
            end
            sltf_pkg::ALU_SUB: begin
                x   = {1'b0, i_a};
                y   = {1'b0, i_b};
                sub = 1'b1;
            end
            sltf_pkg::ALU_CHK: begin
                y   = {1'b0, i_b};
                sub = 1'b1;
            end
            sltf_pkg::ALU_MSTEP: begin
                y = r_lo[0] ? {1'b0, i_b} : '0;
            end
            sltf_pkg::ALU_DSTEP: begin
                x   = {r_hi[AVG_W-1:0], r_lo[LO_W-1]};
                y   = {1'b0, i_b};
                sub = 1'b1;
            end
            default: begin
                x = r_hi;
            end
        endcase
        s      = {1'b0, x} + {1'b0, y ^ {(AVG_W+1){sub}}} + {{(AVG_W+1){1'b0}}, sub};
        borrow = sub & ~s[AVG_W+1];
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            sltf_pkg::ALU_LOAD: begin
                r_hi <= {1'b0, i_a};
                r_lo <= i_lo;
            end
            sltf_pkg::ALU_MSTEP: begin
                r_hi <= {1'b0, s[AVG_W:1]};
                r_lo <= {s[0], r_lo[LO_W-1:1]};
            end
            sltf_pkg::ALU_DSTEP: begin
                r_hi <= borrow ? x : s[AVG_W:0];
                r_lo <= {r_lo[LO_W-2:0], ~borrow};
            end
            default: begin
                r_hi <= r_hi;
            end
        endcase
    end

    assign o_sum    = s[AVG_W-1:0];
    assign o_borrow = borrow;
    assign o_mres   = {r_hi[AVG_W-2:0], r_lo[LO_W-1]};
    assign o_lo     = r_lo;

endmodule

>>> tb/sltf_checker.sv
module sltf_checker
    import sltf_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [SAMPLE_BITS_DEF-1:0]  i_sample,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [RATIO_W-1:0]          i_ratio,
    input  logic                        i_triggered,
    input  logic                        i_warming_up,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    output int unsigned                 o_errors,
    output int unsigned                 o_pending,
    output logic [WARM_W-1:0]           o_warm_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam logic [63:0] MAG_TOP   = (64'd1 << (SB - 1)) - 64'd1;
    localparam logic [63:0] GAIN_UNIT = 64'd1 << GAIN_FRAC;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic               triggered;
        logic               warming_up;
    } t_result;

    logic [GAIN_W-1:0] sta_g;
    logic [GAIN_W-1:0] lta_g;
    logic [WARM_W-1:0] init_len;
    logic [EVT_W-1:0]  ev_on;
    logic [EVT_W-1:0]  ev_off;

    logic [63:0]       short_mean;
    logic [63:0]       long_mean;
    logic [WARM_W-1:0] warm_taken;
    logic              held;

    t_result     outputs_due[$];
    t_result     want;
    int unsigned mismatches = 0;

    function automatic logic [63:0] gain_move(input logic [63:0] avg, input logic [63:0] goal,
                                              input logic [GAIN_W-1:0] g);
        logic [63:0] gg;
        logic [63:0] d;
        logic [63:0] delta;
        gg = (64'(g) > GAIN_UNIT) ? GAIN_UNIT : 64'(g);
        d = (goal >= avg) ? goal - avg : avg - goal;
        delta = (d >> GAIN_FRAC) * gg + (((d & (GAIN_UNIT - 64'd1)) * gg) >> GAIN_FRAC);
        return (goal >= avg) ? avg + delta : avg - delta;
    endfunction

    function automatic logic [RATIO_W-1:0] ratio_of(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        if (den == 64'd0) return RATIO_MAX;
        if (num / den >= (64'd1 << RATIO_SH)) return RATIO_MAX;
        q = (num << RATIO_FRAC) / den;
        return q[RATIO_W-1:0];
    endfunction

    function automatic t_result step_trigger(input logic [SB-1:0] raw);
        logic [SB-1:0] neg;
        logic [63:0]   mag;
        logic [63:0]   level;
        logic [63:0]   n;
        t_result       r;
        if (raw[SB-1]) begin
            neg = ~raw + 1'b1;
            mag = neg[SB-1] ? MAG_TOP : 64'(neg);
        end else begin
            mag = 64'(raw);
        end
        level = mag << FB;
        if (warm_taken < init_len) begin
            n = 64'(warm_taken) + 64'd1;
            if (level >= long_mean) long_mean = long_mean + (level - long_mean) / n;
            else long_mean = long_mean - (long_mean - level) / n;
            short_mean = long_mean;
            warm_taken = warm_taken + 1'b1;
            r.ratio = RATIO_ONE;
            r.warming_up = 1'b1;
        end else begin
            if (!held) long_mean = gain_move(long_mean, short_mean, lta_g);
            short_mean = gain_move(short_mean, level, sta_g);
            r.ratio = ratio_of(short_mean, long_mean);
            if (!held && r.ratio > ev_on) held = 1'b1;
            else if (held && r.ratio < ev_off) held = 1'b0;
            r.warming_up = 1'b0;
        end
        r.triggered = held;
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%s mismatch at %0t: expected %h, got %h", what, $time, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sta_g = STA_GAIN_RST;
            lta_g = LTA_GAIN_RST;
            init_len = INIT_LEN_RST;
            ev_on = EVENT_ON_RST;
            ev_off = EVENT_OFF_RST;
            short_mean = '0;
            long_mean = '0;
            warm_taken = '0;
            held = 1'b0;
            outputs_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outputs_due.size() == 0) begin
                    flag("unexpected result", 32'd0,
                         32'({i_ratio, i_triggered, i_warming_up}));
                end else begin
                    want = outputs_due.pop_front();
                    if (i_ratio !== want.ratio) flag("ratio", 32'(want.ratio), 32'(i_ratio));
                    if (i_triggered !== want.triggered)
                        flag("triggered", 32'(want.triggered), 32'(i_triggered));
                    if (i_warming_up !== want.warming_up)
                        flag("warming_up", 32'(want.warming_up), 32'(i_warming_up));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STA_GAIN:  sta_g = i_cfg_data[GAIN_W-1:0];
                    CFG_LTA_GAIN:  lta_g = i_cfg_data[GAIN_W-1:0];
                    CFG_INIT_LEN:  init_len = i_cfg_data[WARM_W-1:0];
                    CFG_EVENT_ON:  ev_on = i_cfg_data[EVT_W-1:0];
                    CFG_EVENT_OFF: ev_off = i_cfg_data[EVT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) outputs_due.push_back(step_trigger(i_sample));
        end
        o_errors <= mismatches;
        o_pending <= outputs_due.size();
        o_warm_taken <= warm_taken;
    end

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sltf_pkg::*;

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned PRESSURE_AT = 700;
    localparam int unsigned PHASES      = 9;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int INIT_PAD = CFG_DATA_W - WARM_W;
    localparam int EVT_PAD  = CFG_DATA_W - EVT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam logic [GAIN_W-1:0] GAIN_UNIT = GAIN_W'(1) << GAIN_FRAC;
    localparam int unsigned MAG_TOP = (1 << (SB - 1)) - 1;

    localparam logic [SB-1:0] WARM_PROBES [10] = '{
        24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
        24'h800001, 24'h555555, 24'hAAAAAA, 24'h000100, 24'hFFFF00
    };
    localparam logic [SB-1:0] EDGE_PROBES [10] = '{
        24'h0003E8, 24'h000000, 24'h000000, 24'h000000, 24'h07A120,
        24'h07A120, 24'h7FFFFF, 24'h800000, 24'h000003, 24'h000000
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic signed [SB-1:0]   i_sample;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [RATIO_W-1:0]     o_ratio;
    logic                   o_triggered;
    logic                   o_warming_up;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int unsigned            errors;
    int unsigned            pending;
    logic [WARM_W-1:0]      warm_taken;

    int unsigned sent = 0;
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 46;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned quiet_amp = 1;
    int unsigned burst_amp = 0;
    int unsigned burst_left = 0;

    sta_lta_trigger_freeze uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ratio      (o_ratio),
        .o_triggered  (o_triggered),
        .o_warming_up (o_warming_up),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    sltf_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_ratio      (o_ratio),
        .i_triggered  (o_triggered),
        .i_warming_up (o_warming_up),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_warm_taken (warm_taken)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic put_sample(input logic [SB-1:0] s);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        if (sent == PRESSURE_AT) hold_req = 1'b1;
        if (sent < 300) begin
            tx_idle_pct = 10;
            rx_idle_pct = 46;
        end else if (sent < 600) begin
            tx_idle_pct = 46;
            rx_idle_pct = 10;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // unused upper data bits carry noise and must be dropped by the block
    task automatic program_regs(input logic [GAIN_W-1:0] sta, input logic [GAIN_W-1:0] lta,
                                input logic [WARM_W-1:0] warm_len,
                                input logic [EVT_W-1:0] on_lvl, input logic [EVT_W-1:0] off_lvl);
        write_reg(CFG_STA_GAIN, sta);
        write_reg(CFG_LTA_GAIN, lta);
        write_reg(CFG_INIT_LEN, {INIT_PAD'($urandom), warm_len});
        write_reg(CFG_EVENT_ON, {EVT_PAD'($urandom), on_lvl});
        write_reg(CFG_EVENT_OFF, {EVT_PAD'($urandom), off_lvl});
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(19))
            0: return '0;
            1: return GAIN_W'(1);
            2: return GAIN_UNIT;
            3: return '1;
            default: return GAIN_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // quiet noise with occasional decaying bursts, a little raw noise and rare full-scale samples
    function automatic logic [SB-1:0] next_sample();
        int unsigned pick;
        int unsigned amp;
        int          v;
        pick = $urandom_range(99);
        if (pick == 99) return {1'b1, {(SB-1){1'b0}}};
        if (pick == 98) return {1'b0, {(SB-1){1'b1}}};
        if (pick >= 96) return SB'($urandom);
        if (burst_left == 0 && pick < 3) begin
            burst_left = $urandom_range(30, 5);
            burst_amp = quiet_amp * $urandom_range(64, 4);
            if (burst_amp > MAG_TOP) burst_amp = MAG_TOP;
        end
        amp = quiet_amp;
        if (burst_left != 0) begin
            amp = burst_amp;
            burst_amp = burst_amp - burst_amp / 8;
            burst_left--;
        end
        v = int'($urandom_range(2 * amp)) - int'(amp);
        return SB'(v);
    endfunction

    initial begin
        int unsigned       phase;
        logic [WARM_W-1:0] warm_len;
        logic [EVT_W-1:0]  on_lvl;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STA_GAIN;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (WARM_PROBES[k]) put_sample(WARM_PROBES[k]);
        drain();
        // shorten warm-up below the count already taken; zero long-term average
        program_regs('1, GAIN_UNIT, 16'd4, 24'd0, 24'hFFFFFF);
        foreach (EDGE_PROBES[k]) put_sample(EDGE_PROBES[k]);

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case ($urandom_range(4))
                0: warm_len = '0;
                1, 2: warm_len = warm_taken + WARM_W'($urandom_range(40, 1));
                default: warm_len = WARM_W'($urandom_range(warm_taken));
            endcase
            on_lvl = ($urandom_range(9) == 0) ? '1 : EVT_W'($urandom_range(24'h60000, 24'h18000));
            case (phase)
                3: program_regs(GAIN_W'(1), GAIN_W'(1), '1, '0, '0);
                5: program_regs('0, '1, warm_len, on_lvl, EVT_W'($urandom_range(24'h18000, 24'h8000)));
                7: program_regs(GAIN_UNIT, GAIN_UNIT, '0, '1, '1);
                default: program_regs(pick_gain(GAIN_UNIT / 32, GAIN_UNIT / 2),
                                      pick_gain(GAIN_UNIT / 1024, GAIN_UNIT / 32),
                                      warm_len, on_lvl,
                                      EVT_W'($urandom_range(24'h18000, 24'h8000)));
            endcase
            quiet_amp = (1 << $urandom_range(14)) + $urandom_range(15);
            burst_left = 0;
            repeat (PHASE_ITEMS) put_sample(next_sample());
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/sltf_pkg.sv
src/sltf_alu.sv
src/sta_lta_trigger_freeze.sv
tb/sltf_checker.sv
tb/tb.sv
